>>> sv/dmaws_pkg.sv
// ----------------------------------------------------------------------------
// dmaws_pkg
// Types, register indexes and command codes shared by the DMA write
// sequencer, its decoder and its checker.
// ----------------------------------------------------------------------------
package dmaws_pkg;

    localparam int DATA_W    = 8;
    localparam int TGT_W     = 5;
    localparam int CMD_W     = 5;
    localparam int PCOUNT_W  = 3;
    localparam int PUSH_MAX  = 4;   // most follow-ups one byte can queue
    localparam int PUSH_CW   = 3;
    localparam int M_TDATA_W = 24;

    localparam logic [DATA_W-1:0] READ_VALUE = 8'hff;

    // Register indexes
    localparam logic [TGT_W-1:0] R_WR0    = 5'd0;
    localparam logic [TGT_W-1:0] R_WR1    = 5'd1;
    localparam logic [TGT_W-1:0] R_WR2    = 5'd2;
    localparam logic [TGT_W-1:0] R_WR3    = 5'd3;
    localparam logic [TGT_W-1:0] R_WR4    = 5'd4;
    localparam logic [TGT_W-1:0] R_WR5    = 5'd5;
    localparam logic [TGT_W-1:0] R_WR6    = 5'd6;
    localparam logic [TGT_W-1:0] R_A_LO   = 5'd7;
    localparam logic [TGT_W-1:0] R_A_HI   = 5'd8;
    localparam logic [TGT_W-1:0] R_LEN_LO = 5'd9;
    localparam logic [TGT_W-1:0] R_LEN_HI = 5'd10;
    localparam logic [TGT_W-1:0] R_TIM_A  = 5'd11;
    localparam logic [TGT_W-1:0] R_TIM_B  = 5'd12;
    localparam logic [TGT_W-1:0] R_MASK   = 5'd13;
    localparam logic [TGT_W-1:0] R_CMP    = 5'd14;
    localparam logic [TGT_W-1:0] R_B_LO   = 5'd15;
    localparam logic [TGT_W-1:0] R_B_HI   = 5'd16;
    localparam logic [TGT_W-1:0] R_IRQ    = 5'd17;
    localparam logic [TGT_W-1:0] R_PULSE  = 5'd18;
    localparam logic [TGT_W-1:0] R_VEC    = 5'd19;
    localparam logic [TGT_W-1:0] R_RMASK  = 5'd20;

    // WR6 command codes
    localparam logic [CMD_W-1:0] CMD_NONE      = 5'd0;
    localparam logic [CMD_W-1:0] CMD_RESET     = 5'd1;
    localparam logic [CMD_W-1:0] CMD_RST_PA    = 5'd2;
    localparam logic [CMD_W-1:0] CMD_RST_PB    = 5'd3;
    localparam logic [CMD_W-1:0] CMD_LOAD      = 5'd4;
    localparam logic [CMD_W-1:0] CMD_CONTINUE  = 5'd5;
    localparam logic [CMD_W-1:0] CMD_DIS_INT   = 5'd6;
    localparam logic [CMD_W-1:0] CMD_EN_INT    = 5'd7;
    localparam logic [CMD_W-1:0] CMD_RST_DIS   = 5'd8;
    localparam logic [CMD_W-1:0] CMD_EN_AFTER  = 5'd9;
    localparam logic [CMD_W-1:0] CMD_RD_STAT   = 5'd10;
    localparam logic [CMD_W-1:0] CMD_REINIT_ST = 5'd11;
    localparam logic [CMD_W-1:0] CMD_INIT_RD   = 5'd12;
    localparam logic [CMD_W-1:0] CMD_FORCE_RDY = 5'd13;
    localparam logic [CMD_W-1:0] CMD_ENABLE    = 5'd14;
    localparam logic [CMD_W-1:0] CMD_DISABLE   = 5'd15;
    localparam logic [CMD_W-1:0] CMD_RD_MASK   = 5'd16;
    localparam logic [CMD_W-1:0] CMD_INVALID   = 5'd17;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              stored;
        logic [TGT_W-1:0]  target_register;
        logic [CMD_W-1:0]  command_code;
    } result_t;

    typedef struct packed {
        logic [PUSH_MAX-1:0][TGT_W-1:0] entry;   // entry 0 goes in first
        logic [PUSH_CW-1:0]             count;
        logic                           pop;
    } push_t;

    function automatic logic [CMD_W-1:0] classify_cmd(input logic [DATA_W-1:0] v);
        logic [CMD_W-1:0] c;
        case (v)
            8'hc3:   c = CMD_RESET;
            8'hc7:   c = CMD_RST_PA;
            8'hcb:   c = CMD_RST_PB;
            8'hcf:   c = CMD_LOAD;
            8'hd3:   c = CMD_CONTINUE;
            8'haf:   c = CMD_DIS_INT;
            8'hab:   c = CMD_EN_INT;
            8'ha3:   c = CMD_RST_DIS;
            8'hb7:   c = CMD_EN_AFTER;
            8'hbf:   c = CMD_RD_STAT;
            8'h8b:   c = CMD_REINIT_ST;
            8'ha7:   c = CMD_INIT_RD;
            8'hb3:   c = CMD_FORCE_RDY;
            8'h87:   c = CMD_ENABLE;
            8'h83:   c = CMD_DISABLE;
            8'hbb:   c = CMD_RD_MASK;
            default: c = CMD_INVALID;
        endcase
        return c;
    endfunction

endpackage

>>> sv/dmaws_decode.sv
// ----------------------------------------------------------------------------
// dmaws_decode
// Decodes one port access: base register, follow-up target, WR6 command and
// the follow-up registers to queue, packed in hardware pop order reversed.
// ----------------------------------------------------------------------------
module dmaws_decode (
    input  logic                            action,
    input  logic [dmaws_pkg::DATA_W-1:0]    write_data,
    input  logic                            pending,      // follow-up expected
    input  logic [dmaws_pkg::TGT_W-1:0]     pop_target,
    output dmaws_pkg::result_t              result,
    output dmaws_pkg::push_t                push
);
    import dmaws_pkg::*;

    logic [PUSH_MAX-1:0][TGT_W-1:0] cand;
    logic [PUSH_MAX-1:0]            cand_en;
    logic [DATA_W-1:0]              v;
    logic                           pop;

    assign v = write_data;

    always_comb begin
        result  = '0;
        cand    = '0;
        cand_en = '0;
        pop     = 1'b0;
        if (action) begin
            result.read_data = READ_VALUE;
        end else if (pending) begin
            pop                    = 1'b1;
            result.stored          = 1'b1;
            result.target_register = pop_target;
            if (pop_target == R_IRQ) begin
                cand[0] = R_VEC;   cand_en[0] = v[4];
                cand[1] = R_PULSE; cand_en[1] = v[3];
            end
        end else if (!v[7]) begin
            result.stored = 1'b1;
            if (v[1:0] != 2'b00) begin
                result.target_register = R_WR0;
                cand[0] = R_LEN_HI; cand_en[0] = v[6];
                cand[1] = R_LEN_LO; cand_en[1] = v[5];
                cand[2] = R_A_HI;   cand_en[2] = v[4];
                cand[3] = R_A_LO;   cand_en[3] = v[3];
            end else if (v[2:0] == 3'b100) begin
                result.target_register = R_WR1;
                cand[0] = R_TIM_A; cand_en[0] = v[6];
            end else begin
                result.target_register = R_WR2;
                cand[0] = R_TIM_B; cand_en[0] = v[6];
            end
        end else begin
            case (v[1:0])
                2'b00: begin
                    result.stored          = 1'b1;
                    result.target_register = R_WR3;
                    cand[0] = R_CMP;  cand_en[0] = v[4];
                    cand[1] = R_MASK; cand_en[1] = v[3];
                end
                2'b01: begin
                    result.stored          = 1'b1;
                    result.target_register = R_WR4;
                    cand[0] = R_IRQ;  cand_en[0] = v[4];
                    cand[1] = R_B_HI; cand_en[1] = v[3];
                    cand[2] = R_B_LO; cand_en[2] = v[2];
                end
                2'b11: begin
                    result.stored          = 1'b1;
                    result.target_register = R_WR6;
                    result.command_code    = classify_cmd(v);
                    cand[0] = R_RMASK; cand_en[0] = (v == 8'hbb);
                end
                default: begin
                    // low bits 10: only WR5 matches, anything else is dropped
                    if ((v & 8'hc7) == 8'h82) begin
                        result.stored          = 1'b1;
                        result.target_register = R_WR5;
                    end
                end
            endcase
        end
    end

    // pack the enabled candidates, keeping their order
    always_comb begin
        push.pop   = pop;
        push.entry = '0;
        push.count = '0;
        for (int k = 0; k < PUSH_MAX; k++) begin
            if (cand_en[k]) begin
                push.entry[push.count[1:0]] = cand[k];
                push.count = push.count + PUSH_CW'(1);
            end
        end
    end

endmodule

>>> sv/dma_register_write_sequencer.sv
// ----------------------------------------------------------------------------
// dma_register_write_sequencer
// Write sequencer for the control port of a Z80-style DMA controller.
// ----------------------------------------------------------------------------
// Each request is one processor access to the DMA port and yields exactly one
// result. A request passes an input register, is decoded combinationally
// against the pending follow-up list and lands in the result register, so a
// new request is taken every clock while the result side keeps up; the
// result register drives m_axis_tvalid. The follow-up list is a small
// register stack of PENDING_DEPTH entries; pushes beyond its depth are lost.
// No clearing pass is needed after reset.
module dma_register_write_sequencer #(
    parameter int PENDING_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] write_data
    input  logic        s_axis_tuser,   // [0] action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] read_data, [8] stored, [13:9] target_register,
    // [18:14] command_code, [21:19] pending_count, [23:22] zero
    output logic [dmaws_pkg::M_TDATA_W-1:0] m_axis_tdata
);
    import dmaws_pkg::*;

    localparam int IDX_W = $clog2(PENDING_DEPTH);
    localparam int TOP_W = $clog2(PENDING_DEPTH + 1);
    localparam int SUM_W = TOP_W + PUSH_CW;

    logic              in_valid_reg;
    logic              in_action_reg;
    logic [DATA_W-1:0] in_data_reg;

    logic [TGT_W-1:0]  list_reg  [PENDING_DEPTH];
    logic [TGT_W-1:0]  list_next [PENDING_DEPTH];
    logic [TOP_W-1:0]  top_reg, top_next;

    logic              out_valid_reg;
    result_t           out_res_reg;
    logic [PCOUNT_W-1:0] out_count_reg;

    logic              advance, fire;
    logic [IDX_W-1:0]  pop_idx;
    result_t           dec_res;
    push_t             dec_push;
    logic [TOP_W-1:0]  base;
    logic [SUM_W-1:0]  sum;

    assign advance       = !out_valid_reg || m_axis_tready;
    assign fire          = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;
    assign pop_idx       = IDX_W'(top_reg - TOP_W'(1));

    dmaws_decode u_decode (
        .action     (in_action_reg),
        .write_data (in_data_reg),
        .pending    (top_reg != '0),
        .pop_target (list_reg[pop_idx]),
        .result     (dec_res),
        .push       (dec_push)
    );

    always_comb begin
        logic [SUM_W-1:0] pos;
        base      = dec_push.pop ? top_reg - TOP_W'(1) : top_reg;
        list_next = list_reg;
        for (int k = 0; k < PUSH_MAX; k++) begin
            pos = SUM_W'(base) + SUM_W'(k);
            if (PUSH_CW'(k) < dec_push.count && pos < SUM_W'(PENDING_DEPTH)) begin
                list_next[pos[IDX_W-1:0]] = dec_push.entry[k];
            end
        end
        sum      = SUM_W'(base) + SUM_W'(dec_push.count);
        top_next = (sum > SUM_W'(PENDING_DEPTH)) ? TOP_W'(PENDING_DEPTH) : TOP_W'(sum);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            top_reg       <= '0;
        end else begin
            if (s_axis_tready) begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
            if (fire) begin
                top_reg <= top_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_action_reg <= s_axis_tuser;
            in_data_reg   <= s_axis_tdata;
        end
        if (fire) begin
            list_reg      <= list_next;
            out_res_reg   <= dec_res;
            out_count_reg <= PCOUNT_W'(top_next);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_count_reg, out_res_reg.command_code,
                            out_res_reg.target_register, out_res_reg.stored,
                            out_res_reg.read_data};

endmodule

>>> sv/dmaws_checker.sv
// ----------------------------------------------------------------------------
// dmaws_checker
// Port-level checks on the result stream of the DMA write sequencer.
// ----------------------------------------------------------------------------
module dmaws_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [dmaws_pkg::M_TDATA_W-1:0] m_axis_tdata
);
    import dmaws_pkg::*;

    // a read neither stores nor carries a command
    a_read_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[7:0] != 8'h00 |->
            m_axis_tdata[7:0] == READ_VALUE && !m_axis_tdata[8]
            && m_axis_tdata[18:14] == CMD_NONE)
        else $error("read result carries write fields");

    // a command code only comes with a stored WR6 byte
    a_cmd_wr6: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[18:14] != CMD_NONE |->
            m_axis_tdata[8] && m_axis_tdata[13:9] == R_WR6)
        else $error("command code without WR6 store");

    // nothing stored means no target and clean padding
    a_unstored: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tdata[8] |->
            m_axis_tdata[13:9] == R_WR0 && m_axis_tdata[23:22] == 2'b00)
        else $error("target reported for an unstored request");

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

endmodule

bind dma_register_write_sequencer dmaws_checker u_dmaws_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

>>> bench/dma_register_write_sequencer_tb.sv
// ----------------------------------------------------------------------------
// dma_register_write_sequencer_tb
// Self-checking bench for the DMA port write sequencer. Processor reads and
// writes go in on the request stream and each result is checked against a
// predictor that tracks the follow-up register stack. A directed run covers
// every base register, every follow-up and the read-mask WR6 command. A long
// random run follows, with idle cycles on both sides and one long result hold-off.
// ----------------------------------------------------------------------------
module dma_register_write_sequencer_tb;

    import dmaws_pkg::*;

    localparam int STACK_DEPTH  = 4;
    localparam int RANDOM_ITEMS = 1800;
    localparam int HOLD_CYCLES  = 200;
    localparam int STALL_LIMIT  = 2000;
    localparam logic ACT_WRITE  = 1'b0;
    localparam logic ACT_READ   = 1'b1;

    // in the same order as CMD_RESET .. CMD_RD_MASK
    localparam logic [7:0] WR6_OPCODES [16] = '{
        8'hc3, 8'hc7, 8'hcb, 8'hcf, 8'hd3, 8'haf, 8'hab, 8'ha3,
        8'hb7, 8'hbf, 8'h8b, 8'ha7, 8'hb3, 8'h87, 8'h83, 8'hbb
    };

    typedef struct packed {
        logic [1:0]          pad;
        logic [PCOUNT_W-1:0] pending_count;
        logic [CMD_W-1:0]    command_code;
        logic [TGT_W-1:0]    target_register;
        logic                stored;
        logic [DATA_W-1:0]   read_data;
    } seq_word_t;

    class write_seq_scoreboard;
        logic [TGT_W-1:0]    follow_stack [STACK_DEPTH];
        logic [PCOUNT_W-1:0] follow_top;
        seq_word_t           expected_q [$];
        int                  fails;

        function new();
            follow_top = '0;
            fails      = 0;
        endfunction

        function void push_follow(input logic flag, input logic [TGT_W-1:0] reg_idx);
            if (flag && follow_top < STACK_DEPTH) begin
                follow_stack[follow_top] = reg_idx;
                follow_top++;
            end
        endfunction

        function logic [CMD_W-1:0] wr6_command(input logic [7:0] v);
            for (int i = 0; i < 16; i++)
                if (WR6_OPCODES[i] == v)
                    return CMD_RESET + CMD_W'(i);
            return CMD_INVALID;
        endfunction

        // predict the result of one accepted request
        function void note_request(input logic action, input logic [7:0] d);
            seq_word_t w;
            w = '0;
            if (action == ACT_READ) begin
                w.read_data = READ_VALUE;
            end else if (follow_top != 0) begin
                follow_top--;
                w.stored          = 1'b1;
                w.target_register = follow_stack[follow_top];
                if (w.target_register == R_IRQ) begin
                    // vector goes in first so the pulse offset pops first
                    push_follow(d[4], R_VEC);
                    push_follow(d[3], R_PULSE);
                end
            end else if (!d[7]) begin
                w.stored = 1'b1;
                if (d[1:0] != 2'b00) begin
                    w.target_register = R_WR0;
                    push_follow(d[6], R_LEN_HI);
                    push_follow(d[5], R_LEN_LO);
                    push_follow(d[4], R_A_HI);
                    push_follow(d[3], R_A_LO);
                end else if (d[2:0] == 3'b100) begin
                    w.target_register = R_WR1;
                    push_follow(d[6], R_TIM_A);
                end else begin
                    w.target_register = R_WR2;
                    push_follow(d[6], R_TIM_B);
                end
            end else begin
                case (d[1:0])
                    2'b00: begin
                        w.stored          = 1'b1;
                        w.target_register = R_WR3;
                        push_follow(d[4], R_CMP);
                        push_follow(d[3], R_MASK);
                    end
                    2'b01: begin
                        w.stored          = 1'b1;
                        w.target_register = R_WR4;
                        push_follow(d[4], R_IRQ);
                        push_follow(d[3], R_B_HI);
                        push_follow(d[2], R_B_LO);
                    end
                    2'b11: begin
                        w.stored          = 1'b1;
                        w.target_register = R_WR6;
                        w.command_code    = wr6_command(d);
                        push_follow(d == 8'hbb, R_RMASK);
                    end
                    default: begin
                        // only the WR5 pattern lands, the rest is dropped
                        if ((d & 8'hc7) == 8'h82) begin
                            w.stored          = 1'b1;
                            w.target_register = R_WR5;
                        end
                    end
                endcase
            end
            w.pending_count = follow_top;
            expected_q.push_back(w);
        endfunction

        function void check_field(input string name, input int exp_v, input int act_v);
            if (exp_v != act_v) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, exp_v, act_v);
                fails++;
            end
        endfunction

        function void check_result(input seq_word_t a);
            seq_word_t e;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h",
                         $time, a);
                fails++;
                return;
            end
            e = expected_q.pop_front();
            check_field("read_data", e.read_data, a.read_data);
            check_field("stored", e.stored, a.stored);
            check_field("target_register", e.target_register, a.target_register);
            check_field("command_code", e.command_code, a.command_code);
            check_field("pending_count", e.pending_count, a.pending_count);
            check_field("pad", e.pad, a.pad);
        endfunction
    endclass

    logic                   aclk          = 1'b0;
    logic                   aresetn       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [7:0]             s_axis_tdata  = '0;
    logic                   s_axis_tuser  = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_axis_tdata;

    write_seq_scoreboard    sb = new();
    bit                     idle_on  = 1'b1;
    bit                     hold_req = 1'b0;
    int                     stall_cycles = 0;

    dma_register_write_sequencer i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #4 aclk = ~aclk;

    // accepted requests feed the predictor, accepted results are checked
    always @(posedge aclk) begin
        if (aresetn && s_axis_tvalid && s_axis_tready)
            sb.note_request(s_axis_tuser, s_axis_tdata);
        if (aresetn && m_axis_tvalid && m_axis_tready)
            sb.check_result(seq_word_t'(m_axis_tdata));
    end

    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // result side: random back-pressure, plus one long hold-off on request
    initial begin
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end else begin
                m_axis_tready <= !(idle_on && $urandom_range(99) < 13);
                @(posedge aclk);
            end
        end
    end

    task automatic send_item(input logic action, input logic [7:0] d);
        while (idle_on && $urandom_range(99) < 13) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= action;
        s_axis_tdata  <= d;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
    endtask

    function automatic logic [7:0] random_byte();
        case ($urandom_range(3))
            0, 1:    return 8'($urandom_range(255));
            2:       return WR6_OPCODES[$urandom_range(15)];
            // base byte with most follow flags raised, for deep sequences
            default: return 8'($urandom_range(255)) | 8'h78;
        endcase
    endfunction

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_item(ACT_READ, 8'h00);
        // WR0 with all four follow-ups
        send_item(ACT_WRITE, 8'h79);
        send_item(ACT_WRITE, 8'h00);
        send_item(ACT_WRITE, 8'hff);
        send_item(ACT_READ, 8'hff);
        send_item(ACT_WRITE, 8'h12);
        send_item(ACT_WRITE, 8'h34);
        // WR1 and WR2 with their timing bytes
        send_item(ACT_WRITE, 8'h44);
        send_item(ACT_WRITE, 8'h0e);
        send_item(ACT_WRITE, 8'h40);
        send_item(ACT_WRITE, 8'h0f);
        send_item(ACT_WRITE, 8'h00);
        // WR3 with mask and compare
        send_item(ACT_WRITE, 8'h98);
        send_item(ACT_WRITE, 8'h55);
        send_item(ACT_WRITE, 8'haa);
        // WR4: port B address, then interrupt control with pulse and vector
        send_item(ACT_WRITE, 8'h9d);
        send_item(ACT_WRITE, 8'h01);
        send_item(ACT_WRITE, 8'h80);
        send_item(ACT_WRITE, 8'h18);
        send_item(ACT_WRITE, 8'h20);
        send_item(ACT_WRITE, 8'h7e);
        // WR5, an unmatched byte, read-mask command, invalid WR6 byte
        send_item(ACT_WRITE, 8'h82);
        send_item(ACT_WRITE, 8'hfe);
        send_item(ACT_WRITE, 8'hbb);
        send_item(ACT_WRITE, 8'h7f);
        send_item(ACT_WRITE, 8'hff);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            idle_on = !(n >= 600 && n < 900);
            if (n == 300)
                hold_req = 1'b1;
            if ($urandom_range(9) == 0)
                send_item(ACT_READ, 8'($urandom_range(255)));
            else
                send_item(ACT_WRITE, random_byte());
        end
        s_axis_tvalid <= 1'b0;

        // let the last accepted request reach the predictor first
        @(posedge aclk);
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (sb.fails == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
